// File: rtl/fsts_pkg.sv
`default_nettype none
package fsts_pkg;

    localparam int CLAMP_MAX  = 15;
    localparam int ALPHA_BITS = 16;

    localparam int SEL_W   = 4;
    localparam int BASE_W  = 21;
    localparam int MCU_W   = 8;
    localparam int THR_W   = 32;
    localparam int TIME_W  = 64;
    localparam int STEP_W  = 24;
    localparam int TICKS_W = 8;
    localparam int ALPHA_W = ALPHA_BITS + 1;
    localparam int DROP_W  = 32;
    localparam int DEBT_W  = 33;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 2;

    // dividend is debt plus elapsed time, scaled by 2^ALPHA_BITS; one quotient bit per cycle
    localparam int DIVD_W    = DEBT_W + ALPHA_BITS;
    localparam int DIV_STEPS = DIVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(1048576);
    localparam logic [BASE_W-1:0] BASE_RST   = BASE_W'(20000);
    localparam logic [MCU_W-1:0]  MCU_RST    = MCU_W'(5);
    localparam logic [THR_W-1:0]  THR_RST    = THR_W'(300000);
    localparam logic [SEL_W-1:0]  CLAMP_RST  = SEL_W'(1);
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_BITS;

    localparam logic [CIDX_W-1:0] CFG_BASE_PERIOD = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_MAX_CATCH   = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] CFG_SUSPEND_THR = CIDX_W'(2);

    typedef struct packed {
        logic load;
        logic prep;
        logic eval;
        logic iter;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic div_last;
    } t_stat;

endpackage
`default_nettype wire

// File: rtl/fsts_ctrl.sv
`default_nettype none
module fsts_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  wire              i_ready,
    input  fsts_pkg::t_stat  i_stat,
    output fsts_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.skip ? S_FIN : S_DIV;
            end
            S_DIV: begin
                o_cmd.iter = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register can take the result
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// File: rtl/fsts_dp.sv
`default_nettype none
module fsts_dp (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [fsts_pkg::CIDX_W-1:0]       i_cfg_idx,
    input  wire  [fsts_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire                               i_kind,
    input  wire  [fsts_pkg::TIME_W-1:0]       i_now_time,
    input  wire  [fsts_pkg::SEL_W-1:0]        i_frame_clamp,
    input  fsts_pkg::t_cmd                    i_cmd,
    output fsts_pkg::t_stat                   o_stat,
    output logic [fsts_pkg::TICKS_W-1:0]      o_ticks,
    output logic [fsts_pkg::STEP_W-1:0]       o_step_length,
    output logic [fsts_pkg::ALPHA_W-1:0]      o_alpha,
    output logic [fsts_pkg::TIME_W-1:0]       o_next_deadline,
    output logic [fsts_pkg::DROP_W-1:0]       o_discarded
);

    // configuration
    logic [fsts_pkg::BASE_W-1:0]  r_base;
    logic [fsts_pkg::MCU_W-1:0]   r_mcu;
    logic [fsts_pkg::THR_W-1:0]   r_thr;

    // scheduler state
    logic                         r_armed;
    logic [fsts_pkg::SEL_W-1:0]   r_held;
    logic [fsts_pkg::TIME_W-1:0]  r_last;
    logic [fsts_pkg::STEP_W-1:0]  r_debt;
    logic [fsts_pkg::DROP_W-1:0]  r_drop;

    // item in flight
    logic                         r_kind;
    logic [fsts_pkg::TIME_W-1:0]  r_now;
    logic [fsts_pkg::SEL_W-1:0]   r_sel;
    logic [fsts_pkg::STEP_W-1:0]  r_step;
    logic [fsts_pkg::TIME_W-1:0]  r_elapsed;
    logic                         r_back;
    logic                         r_zero;
    logic                         r_rearm;

    // divider
    logic [fsts_pkg::DIVD_W-1:0]  r_div;
    logic [fsts_pkg::STEP_W-1:0]  r_prem;
    logic [fsts_pkg::STEP_W-1:0]  r_rem;
    logic [fsts_pkg::CNT_W-1:0]   r_cnt;

    logic [fsts_pkg::SEL_W-1:0]   sel_sat;
    logic [fsts_pkg::BASE_W-1:0]  base_clamped;
    logic [fsts_pkg::BASE_W+fsts_pkg::SEL_W-1:0] step_prod;
    logic [fsts_pkg::STEP_W-1:0]  step_val;
    logic                         rearm;
    logic                         suspend;
    logic [fsts_pkg::DEBT_W-1:0]  debt_sum;
    logic [fsts_pkg::STEP_W:0]    shifted;
    logic                         ge;
    logic [fsts_pkg::STEP_W:0]    diff;
    logic [fsts_pkg::STEP_W-1:0]  n_prem;
    logic [fsts_pkg::DEBT_W-1:0]  due;
    logic [fsts_pkg::MCU_W-1:0]   limit;
    logic [fsts_pkg::TICKS_W-1:0] ticks;
    logic [fsts_pkg::DEBT_W-1:0]  excess;
    logic [fsts_pkg::ALPHA_W-1:0] alpha_raw;
    logic [fsts_pkg::ALPHA_W-1:0] alpha;

    assign sel_sat = (i_frame_clamp > fsts_pkg::SEL_W'(fsts_pkg::CLAMP_MAX))
                   ? fsts_pkg::SEL_W'(fsts_pkg::CLAMP_MAX) : i_frame_clamp;

    assign base_clamped = (r_base < fsts_pkg::BASE_MIN) ? fsts_pkg::BASE_MIN
                        : (r_base > fsts_pkg::BASE_MAX) ? fsts_pkg::BASE_MAX : r_base;
    assign step_prod = r_sel * base_clamped;
    assign step_val  = (r_sel == '0)
                     ? fsts_pkg::STEP_W'(base_clamped >> 1)
                     : step_prod[fsts_pkg::STEP_W-1:0];

    assign rearm   = r_kind || !r_armed || (r_sel != r_held) || r_back;
    assign suspend = (r_elapsed >= {{(fsts_pkg::TIME_W-fsts_pkg::THR_W){1'b0}}, r_thr});
    assign debt_sum = {{(fsts_pkg::DEBT_W-fsts_pkg::STEP_W){1'b0}}, r_debt}
                    + r_elapsed[fsts_pkg::DEBT_W-1:0];

    assign o_stat.skip     = rearm || suspend;
    assign o_stat.div_last = (r_cnt == fsts_pkg::CNT_W'(fsts_pkg::DIV_STEPS - 1));

    // restoring division, one quotient bit per cycle
    assign shifted = {r_prem, r_div[fsts_pkg::DIVD_W-1]};
    assign diff    = shifted - {1'b0, r_step};
    assign ge      = (shifted >= {1'b0, r_step});
    assign n_prem  = ge ? diff[fsts_pkg::STEP_W-1:0] : shifted[fsts_pkg::STEP_W-1:0];

    // integer part of the quotient is the step count, fraction is alpha
    assign due    = r_div[fsts_pkg::DIVD_W-1:fsts_pkg::ALPHA_BITS];
    assign limit  = (r_mcu == '0) ? fsts_pkg::MCU_W'(1) : r_mcu;
    assign ticks  = (due < {{(fsts_pkg::DEBT_W-fsts_pkg::MCU_W){1'b0}}, limit})
                  ? due[fsts_pkg::TICKS_W-1:0] : limit;
    assign excess = due - {{(fsts_pkg::DEBT_W-fsts_pkg::TICKS_W){1'b0}}, ticks};
    assign alpha_raw = {1'b0, r_div[fsts_pkg::ALPHA_BITS-1:0]};
    assign alpha     = (alpha_raw > fsts_pkg::ALPHA_ONE) ? fsts_pkg::ALPHA_ONE : alpha_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= fsts_pkg::BASE_RST;
            r_mcu  <= fsts_pkg::MCU_RST;
            r_thr  <= fsts_pkg::THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fsts_pkg::CFG_BASE_PERIOD: r_base <= i_cfg_data[fsts_pkg::BASE_W-1:0];
                fsts_pkg::CFG_MAX_CATCH:   r_mcu  <= i_cfg_data[fsts_pkg::MCU_W-1:0];
                fsts_pkg::CFG_SUSPEND_THR: r_thr  <= i_cfg_data[fsts_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_held  <= fsts_pkg::CLAMP_RST;
            r_last  <= '0;
            r_debt  <= '0;
            r_drop  <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.eval) begin
                r_cnt <= '0;
            end else if (i_cmd.iter) begin
                r_cnt <= r_cnt + fsts_pkg::CNT_W'(1);
            end
            if (i_cmd.finish) begin
                r_last <= r_now;
                if (r_zero) begin
                    r_debt <= '0;
                    if (r_rearm) begin
                        r_armed <= 1'b1;
                        r_held  <= r_sel;
                    end
                end else begin
                    r_debt <= r_rem;
                    r_drop <= r_drop + excess[fsts_pkg::DROP_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_now  <= i_now_time;
            r_sel  <= sel_sat;
        end
        if (i_cmd.prep) begin
            r_step    <= step_val;
            r_elapsed <= r_now - r_last;
            r_back    <= (r_now < r_last);
        end
        if (i_cmd.eval) begin
            r_zero  <= rearm || suspend;
            r_rearm <= rearm;
            r_div   <= {debt_sum, {fsts_pkg::ALPHA_BITS{1'b0}}};
            r_prem  <= '0;
        end
        if (i_cmd.iter) begin
            r_div  <= {r_div[fsts_pkg::DIVD_W-2:0], ge};
            r_prem <= n_prem;
            // remainder once the integer quotient bits are done
            if (r_cnt == fsts_pkg::CNT_W'(fsts_pkg::DEBT_W - 1)) begin
                r_rem <= n_prem;
            end
        end
        if (i_cmd.finish) begin
            o_step_length <= r_step;
            if (r_zero) begin
                o_ticks         <= '0;
                o_alpha         <= '0;
                o_next_deadline <= r_now + {{(fsts_pkg::TIME_W-fsts_pkg::STEP_W){1'b0}}, r_step};
                o_discarded     <= r_drop;
            end else begin
                o_ticks         <= ticks;
                o_alpha         <= alpha;
                o_next_deadline <= r_now
                                 + {{(fsts_pkg::TIME_W-fsts_pkg::STEP_W){1'b0}}, r_step}
                                 - {{(fsts_pkg::TIME_W-fsts_pkg::STEP_W){1'b0}}, r_rem};
                o_discarded     <= r_drop + excess[fsts_pkg::DROP_W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/fixed_step_tick_scheduler_core.sv
// An advance item passes through prepare, evaluate, the radix-2 divider
// iterations (one per bit of the 49-bit dividend) and finish; a restart or
// suspend skips the divider. A new input transfer is taken only while the
// block is idle, once the previous item has finished, and finish waits while
// the output register holds a result not yet taken. A pending result does not block the next input transfer.
// Reset (synchronous, active low) restores register defaults and disarms.
`default_nettype none
module fixed_step_tick_scheduler_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [fsts_pkg::CIDX_W-1:0]       i_cfg_idx,
    input  wire  [fsts_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire                               i_valid,
    output logic                              o_ready,
    input  wire                               i_kind,
    input  wire  [fsts_pkg::TIME_W-1:0]       i_now_time,
    input  wire  [fsts_pkg::SEL_W-1:0]        i_frame_clamp,
    output logic                              o_valid,
    input  wire                               i_ready,
    output logic [fsts_pkg::TICKS_W-1:0]      o_ticks,
    output logic [fsts_pkg::STEP_W-1:0]       o_step_length,
    output logic [fsts_pkg::ALPHA_W-1:0]      o_alpha,
    output logic [fsts_pkg::TIME_W-1:0]       o_next_deadline,
    output logic [fsts_pkg::DROP_W-1:0]       o_discarded
);

    fsts_pkg::t_cmd  cmd;
    fsts_pkg::t_stat stat;

    fsts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    fsts_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_now_time      (i_now_time),
        .i_frame_clamp   (i_frame_clamp),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_ticks         (o_ticks),
        .o_step_length   (o_step_length),
        .o_alpha         (o_alpha),
        .o_next_deadline (o_next_deadline),
        .o_discarded     (o_discarded)
    );

endmodule
`default_nettype wire

// File: tb/tb_fixed_step_tick_scheduler_core.sv
module tb_fixed_step_tick_scheduler_core;
    import fsts_pkg::*;

    localparam logic KIND_ADVANCE = 1'b0;
    localparam logic KIND_RESTART = 1'b1;
    localparam logic [CIDX_W-1:0] CFG_UNUSED = CIDX_W'(3);
    localparam int HOLD_AFTER_ITEMS = 250;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES = 60;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_op;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} t_rx_mode;

    typedef struct packed {
        logic [TICKS_W-1:0] ticks;
        logic [STEP_W-1:0]  step;
        logic [ALPHA_W-1:0] alpha;
        logic [TIME_W-1:0]  deadline;
        logic [DROP_W-1:0]  discarded;
    } t_tick_res;

    typedef struct packed {
        t_row_op            op;
        logic [CIDX_W-1:0]  idx;
        logic [CFG_W-1:0]   data;
        logic               kind;
        logic [TIME_W-1:0]  now;
        logic [SEL_W-1:0]   clamp;
        logic               chk;
        t_tick_res          res;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CIDX_W-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]    i_cfg_data;
    logic                i_valid;
    logic                o_ready;
    logic                i_kind;
    logic [TIME_W-1:0]   i_now_time;
    logic [SEL_W-1:0]    i_frame_clamp;
    logic                o_valid;
    logic                i_ready;
    logic [TICKS_W-1:0]  o_ticks;
    logic [STEP_W-1:0]   o_step_length;
    logic [ALPHA_W-1:0]  o_alpha;
    logic [TIME_W-1:0]   o_next_deadline;
    logic [DROP_W-1:0]   o_discarded;

    fixed_step_tick_scheduler_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_now_time      (i_now_time),
        .i_frame_clamp   (i_frame_clamp),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_ticks         (o_ticks),
        .o_step_length   (o_step_length),
        .o_alpha         (o_alpha),
        .o_next_deadline (o_next_deadline),
        .o_discarded     (o_discarded)
    );

    // scheduler shadow state and register copies
    logic                sched_armed;
    logic [SEL_W-1:0]    sched_clamp;
    logic [TIME_W-1:0]   sched_last;
    logic [DEBT_W-1:0]   sched_debt;
    logic [DROP_W-1:0]   sched_drops;
    logic [BASE_W-1:0]   cfg_base;
    logic [MCU_W-1:0]    cfg_mcu;
    logic [THR_W-1:0]    cfg_thr;

    t_tick_res tick_reports_q[$];
    int        n_fail;
    int        n_sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("fixed_step_tick_scheduler_core test failed");
        $finish;
    end

    function automatic logic [63:0] step_counts(input logic [SEL_W-1:0] sel);
        logic [63:0] b;
        b = 64'(cfg_base);
        if (b < 64'(BASE_MIN)) b = 64'(BASE_MIN);
        if (b > 64'(BASE_MAX)) b = 64'(BASE_MAX);
        return (sel == '0) ? (b >> 1) : (b * 64'(sel));
    endfunction

    function automatic t_tick_res advance_schedule(input logic kind,
                                                   input logic [TIME_W-1:0] now,
                                                   input logic [SEL_W-1:0] clamp);
        t_tick_res        r;
        logic [SEL_W-1:0] sel;
        logic [63:0]      stp;
        logic [63:0]      elapsed;
        logic [63:0]      acc;
        logic [63:0]      due;
        logic [63:0]      lim;
        logic [63:0]      tk;
        logic [63:0]      frac;
        sel = (32'(clamp) > CLAMP_MAX) ? SEL_W'(CLAMP_MAX) : clamp;
        stp = step_counts(sel);
        r.ticks    = '0;
        r.step     = stp[STEP_W-1:0];
        r.alpha    = '0;
        r.deadline = now + stp;
        if (kind == KIND_RESTART || !sched_armed || sel != sched_clamp || now < sched_last) begin
            sched_armed = 1'b1;
            sched_clamp = sel;
            sched_last  = now;
            sched_debt  = '0;
        end else begin
            elapsed    = now - sched_last;
            sched_last = now;
            if (elapsed >= 64'(cfg_thr)) begin
                sched_debt = '0;
            end else begin
                acc = (64'(sched_debt) + elapsed) & 64'h1_FFFF_FFFF;
                due = acc / stp;
                lim = (cfg_mcu == '0) ? 64'd1 : 64'(cfg_mcu);
                tk  = (due < lim) ? due : lim;
                sched_drops = sched_drops + DROP_W'(due - tk);
                sched_debt  = DEBT_W'(acc % stp);
                frac = (64'(sched_debt) << ALPHA_BITS) / stp;
                if (frac > 64'(ALPHA_ONE)) frac = 64'(ALPHA_ONE);
                r.ticks    = tk[TICKS_W-1:0];
                r.alpha    = frac[ALPHA_W-1:0];
                r.deadline = now + (stp - 64'(sched_debt));
            end
        end
        r.discarded = sched_drops;
        return r;
    endfunction

    function automatic t_stim_row item_row(input logic kind, input logic [TIME_W-1:0] now,
                                           input logic [SEL_W-1:0] clamp);
        t_stim_row r;
        r       = '0;
        r.op    = ROW_ITEM;
        r.kind  = kind;
        r.now   = now;
        r.clamp = clamp;
        return r;
    endfunction

    function automatic t_stim_row checked_row(input logic kind, input logic [TIME_W-1:0] now,
                                              input logic [SEL_W-1:0] clamp,
                                              input logic [TICKS_W-1:0] ticks,
                                              input logic [STEP_W-1:0] step,
                                              input logic [ALPHA_W-1:0] alpha,
                                              input logic [TIME_W-1:0] deadline,
                                              input logic [DROP_W-1:0] discarded);
        t_stim_row r;
        r               = item_row(kind, now, clamp);
        r.chk           = 1'b1;
        r.res.ticks     = ticks;
        r.res.step      = step;
        r.res.alpha     = alpha;
        r.res.deadline  = deadline;
        r.res.discarded = discarded;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [CIDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
        t_stim_row r;
        r      = '0;
        r.op   = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    task automatic send_item(input logic kind, input logic [TIME_W-1:0] now,
                             input logic [SEL_W-1:0] clamp, input logic chk,
                             input t_tick_res typed);
        t_tick_res pred;
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_now_time    <= now;
        i_frame_clamp <= clamp;
        do @(posedge i_clk); while (!o_ready);
        pred = advance_schedule(kind, now, clamp);
        tick_reports_q.push_back(chk ? typed : pred);
        n_sent++;
    endtask

    task automatic put_config(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_BASE_PERIOD: cfg_base = data[BASE_W-1:0];
            CFG_MAX_CATCH:   cfg_mcu  = data[MCU_W-1:0];
            CFG_SUSPEND_THR: cfg_thr  = data[THR_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic hold_input(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (tick_reports_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endtask

    // result side: compare each transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_tick_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (tick_reports_q.size() == 0) begin
                $error("result transfer with no expectation waiting");
                n_fail++;
            end else begin
                want = tick_reports_q.pop_front();
                check_field("ticks", 64'(want.ticks), 64'(o_ticks));
                check_field("step_length", 64'(want.step), 64'(o_step_length));
                check_field("alpha", 64'(want.alpha), 64'(o_alpha));
                check_field("next_deadline", want.deadline, o_next_deadline);
                check_field("discarded", 64'(want.discarded), 64'(o_discarded));
            end
        end
    end

    // receiver stall pattern, with one long hold-off so the block backs up
    initial begin
        t_rx_mode mode;
        int       left;
        int       k;
        logic     hold_done;
        i_ready   <= 1'b0;
        mode      = RX_OPEN;
        left      = 0;
        k         = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && n_sent >= HOLD_AFTER_ITEMS) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            if (left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                left = $urandom_range(20, 300);
            end
            left--;
            k++;
            case (mode)
                RX_OPEN:   i_ready <= 1'b1;
                RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                default:   i_ready <= ((k % 7) < 3);
            endcase
        end
    end

    initial begin
        t_stim_row        dir_rows[$];
        t_stim_row        row;
        t_tick_res        none;
        logic             cfg_busy;
        logic             kind;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] cur_time;
        logic [SEL_W-1:0] cur_clamp;
        logic [63:0]      stp;
        int               burst_left;
        int               r;

        n_fail = 0;
        n_sent = 0;
        none   = '0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_kind        <= KIND_ADVANCE;
        i_now_time    <= '0;
        i_frame_clamp <= '0;

        sched_armed = 1'b0;
        sched_clamp = CLAMP_RST;
        sched_last  = '0;
        sched_debt  = '0;
        sched_drops = '0;
        cfg_base    = BASE_RST;
        cfg_mcu     = MCU_RST;
        cfg_thr     = THR_RST;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: base 20000, catch-up 5, suspend at 300000
        dir_rows.push_back(checked_row(KIND_ADVANCE, 64'd1000, 4'd1,
                                       8'd0, 24'd20000, 17'd0, 64'd21000, 32'd0));
        dir_rows.push_back(checked_row(KIND_ADVANCE, 64'd21000, 4'd1,
                                       8'd1, 24'd20000, 17'd0, 64'd41000, 32'd0));
        dir_rows.push_back(checked_row(KIND_ADVANCE, 64'd31000, 4'd1,
                                       8'd0, 24'd20000, 17'd32768, 64'd41000, 32'd0));
        // eight steps due, five released
        dir_rows.push_back(checked_row(KIND_ADVANCE, 64'd181000, 4'd1,
                                       8'd5, 24'd20000, 17'd0, 64'd201000, 32'd3));
        // gap equal to threshold suspends
        dir_rows.push_back(checked_row(KIND_ADVANCE, 64'd481000, 4'd1,
                                       8'd0, 24'd20000, 17'd0, 64'd501000, 32'd3));
        // one count below threshold
        dir_rows.push_back(checked_row(KIND_ADVANCE, 64'd780999, 4'd1,
                                       8'd5, 24'd20000, 17'd65532, 64'd781000, 32'd12));
        // time going backwards
        dir_rows.push_back(checked_row(KIND_ADVANCE, 64'd500, 4'd1,
                                       8'd0, 24'd20000, 17'd0, 64'd20500, 32'd12));
        // selector change to half period
        dir_rows.push_back(checked_row(KIND_ADVANCE, 64'd1000, 4'd0,
                                       8'd0, 24'd10000, 17'd0, 64'd11000, 32'd12));
        dir_rows.push_back(checked_row(KIND_RESTART, 64'd5000, 4'd0,
                                       8'd0, 24'd10000, 17'd0, 64'd15000, 32'd12));
        dir_rows.push_back(checked_row(KIND_ADVANCE, 64'd5000, 4'd15,
                                       8'd0, 24'd300000, 17'd0, 64'd305000, 32'd12));
        dir_rows.push_back(checked_row(KIND_ADVANCE, 64'd155000, 4'd15,
                                       8'd0, 24'd300000, 17'd32768, 64'd305000, 32'd12));
        // deadline wraps past 2^64
        dir_rows.push_back(checked_row(KIND_RESTART, 64'hFFFF_FFFF_FFFF_FFF0, 4'd15,
                                       8'd0, 24'd300000, 17'd0, 64'd299984, 32'd12));
        dir_rows.push_back(checked_row(KIND_ADVANCE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15,
                                       8'd0, 24'd300000, 17'd3, 64'd299984, 32'd12));
        dir_rows.push_back(checked_row(KIND_ADVANCE, 64'd0, 4'd15,
                                       8'd0, 24'd300000, 17'd0, 64'd300000, 32'd12));
        // smallest step, widest catch-up, threshold never reached
        dir_rows.push_back(cfg_row(CFG_BASE_PERIOD, 32'd2));
        dir_rows.push_back(cfg_row(CFG_MAX_CATCH, 32'd255));
        dir_rows.push_back(cfg_row(CFG_SUSPEND_THR, 32'hFFFF_FFFF));
        dir_rows.push_back(checked_row(KIND_RESTART, 64'd0, 4'd0,
                                       8'd0, 24'd1, 17'd0, 64'd1, 32'd12));
        dir_rows.push_back(checked_row(KIND_ADVANCE, 64'd1000, 4'd0,
                                       8'd255, 24'd1, 17'd0, 64'd1001, 32'd757));
        // drop count wraps
        dir_rows.push_back(item_row(KIND_ADVANCE, 64'd1000 + 64'hFFFF_FFFE, 4'd0));
        dir_rows.push_back(item_row(KIND_ADVANCE, 64'd1000 + 64'hFFFF_FFFE + 64'hFFFF_FFFF,
                                    4'd0));
        // largest step, zero catch-up limit, zero threshold
        dir_rows.push_back(cfg_row(CFG_BASE_PERIOD, 32'd1048576));
        dir_rows.push_back(cfg_row(CFG_MAX_CATCH, 32'd0));
        dir_rows.push_back(cfg_row(CFG_SUSPEND_THR, 32'd0));
        dir_rows.push_back(item_row(KIND_ADVANCE, 64'd7, 4'd15));
        dir_rows.push_back(item_row(KIND_ADVANCE, 64'd100, 4'd15));
        dir_rows.push_back(item_row(KIND_ADVANCE, 64'd100 + 64'd31457280, 4'd15));
        dir_rows.push_back(cfg_row(CFG_UNUSED, 32'hFFFF_FFFF));

        cfg_busy = 1'b0;
        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            if (row.op == ROW_CFG) begin
                if (!cfg_busy) wait_results_done();
                put_config(row.idx, row.data);
                cfg_busy = 1'b1;
            end else begin
                if (cfg_busy) i_cfg_we <= 1'b0;
                cfg_busy = 1'b0;
                send_item(row.kind, row.now, row.clamp, row.chk, row.res);
            end
        end

        for (int phase = 0; phase < 6; phase++) begin
            // registers change only once the block is drained
            wait_results_done();
            case (phase)
                0: begin
                    put_config(CFG_BASE_PERIOD, 32'd20000);
                    put_config(CFG_MAX_CATCH, 32'd5);
                    put_config(CFG_SUSPEND_THR, 32'd300000);
                end
                1: begin
                    put_config(CFG_BASE_PERIOD, 32'd2);
                    put_config(CFG_MAX_CATCH, 32'd255);
                    put_config(CFG_SUSPEND_THR, 32'hFFFF_FFFF);
                end
                2: begin
                    put_config(CFG_BASE_PERIOD, 32'd1048576);
                    put_config(CFG_MAX_CATCH, 32'd1);
                    put_config(CFG_SUSPEND_THR, 32'hFFFF_FFFF);
                    put_config(CFG_UNUSED, 32'h1234_5678);
                end
                3: begin
                    put_config(CFG_BASE_PERIOD, 32'd0);
                    put_config(CFG_MAX_CATCH, 32'd0);
                    put_config(CFG_SUSPEND_THR, 32'($urandom_range(1, 50)));
                end
                4: begin
                    put_config(CFG_BASE_PERIOD, 32'hFFFF_FFFF);
                    put_config(CFG_MAX_CATCH, 32'hFFFF_FF03);
                    put_config(CFG_SUSPEND_THR, 32'($urandom_range(1000, 100000000)));
                end
                default: begin
                    put_config(CFG_BASE_PERIOD, 32'($urandom_range(1, 1500)) | 32'd1);
                    put_config(CFG_MAX_CATCH, 32'($urandom_range(1, 255)));
                    put_config(CFG_SUSPEND_THR, $urandom);
                end
            endcase
            i_cfg_we <= 1'b0;

            cur_time   = (phase == 4) ? 64'hFFFF_FFFF_F000_0000 : {$urandom, $urandom};
            cur_clamp  = SEL_W'($urandom_range(0, 15));
            burst_left = 0;
            for (int i = 0; i < 100; i++) begin
                if (burst_left == 0) begin
                    hold_input($urandom_range(1, 12));
                    burst_left = $urandom_range(1, 30);
                end
                burst_left--;
                stp  = step_counts(cur_clamp);
                kind = KIND_ADVANCE;
                r    = $urandom_range(0, 99);
                if (r < 4) begin
                    kind = KIND_RESTART;
                    now  = cur_time + 64'($urandom_range(0, 1000));
                end else if (r < 9) begin
                    cur_clamp = SEL_W'($urandom_range(0, 15));
                    now = cur_time + 64'($urandom_range(0, 50000));
                end else if (r < 12) begin
                    now = cur_time - 64'($urandom_range(1, 100000));
                end else if (r < 15) begin
                    now = {$urandom, $urandom};
                end else if (r < 19) begin
                    // straddle the suspend threshold
                    now = cur_time + 64'(cfg_thr) - 64'd1 + 64'($urandom_range(0, 2));
                end else if (r < 30) begin
                    now = cur_time + stp * 64'($urandom_range(0, 32'(cfg_mcu) + 3))
                        + 64'($urandom_range(0, 32'(stp - 64'd1)));
                end else begin
                    now = cur_time + stp * 64'($urandom_range(0, 3))
                        + 64'($urandom_range(0, 32'(stp - 64'd1)));
                end
                cur_time = now;
                send_item(kind, now, cur_clamp, 1'b0, none);
            end
        end

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_fail == 0 && tick_reports_q.size() == 0) begin
            $display("fixed_step_tick_scheduler_core test passed");
        end else begin
            $display("fixed_step_tick_scheduler_core test failed");
        end
        $finish;
    end

endmodule
